// File: rtl/lcg_slice_shuffle_descrambler_assert.svh
// assertion macros shared by the descrambler rtl
// expects i_clk and i_rst_n in the module that uses them
`ifndef LCG_SLICE_SHUFFLE_DESCRAMBLER_ASSERT_SVH
`define LCG_SLICE_SHUFFLE_DESCRAMBLER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LCGSD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lcgsd check failed");

// next-cycle implication, checked out of reset
`define LCGSD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lcgsd check failed");

`endif

// File: rtl/lcgsd_pkg.sv
// shared types and constants of the slice shuffle descrambler
// used by lcgsd_perm and lcg_slice_shuffle_descrambler
package lcgsd_pkg;

    localparam int SIZE_W      = 27;
    localparam int OFS_W       = 26;
    localparam int IDX_W       = 16;
    localparam int CNT_W       = IDX_W + 1;
    localparam int SEED_W      = 15;
    localparam int BIS_W       = 5;
    localparam int SLICE_BYTES = 32;
    localparam int TABLE_DEPTH = 65536;
    localparam int MAX_CHUNK_SLICES = 65536;

    localparam logic [SEED_W-1:0] LCG_MUL = 15'd2109;
    localparam logic [SEED_W-1:0] LCG_INC = 15'd9273;
    localparam logic [IDX_W-1:0]  RND_OFS = 16'hc000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BYTE,
        S_SIZE,
        S_FILL,
        S_SLICE
    } t_top_state;

    typedef enum logic [2:0] {
        P_IDLE,
        P_FILL,
        P_LCG,
        P_MUL,
        P_RDI,
        P_RDX,
        P_WRI,
        P_WRX
    } t_perm_state;

    typedef struct packed {
        logic              reseed;
        logic [SEED_W-1:0] seed;
        logic              fill;
        logic [IDX_W-1:0]  last_idx;
        logic              slice;
        logic [IDX_W-1:0]  slice_idx;
    } t_perm_cmd;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] slice_dest;
    } t_perm_sts;

endpackage

// File: rtl/lcgsd_ram.sv
// generic single-clock ram, one write port, one registered read port
// no dependencies
module lcgsd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/lcgsd_perm.sv
// slice index table with generator: identity fill and per-slice swap
// depends on lcgsd_pkg, lcgsd_ram and the assertion header
`include "lcg_slice_shuffle_descrambler_assert.svh"

module lcgsd_perm (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lcgsd_pkg::t_perm_cmd i_cmd,
    output lcgsd_pkg::t_perm_sts o_sts
);

    lcgsd_pkg::t_perm_state r_state, n_state;

    logic [lcgsd_pkg::SEED_W-1:0] r_seed, n_seed;
    logic [lcgsd_pkg::IDX_W-1:0]  r_fill_cnt, n_fill_cnt;
    logic [lcgsd_pkg::IDX_W-1:0]  r_last, n_last;
    logic [lcgsd_pkg::IDX_W-1:0]  r_i, n_i;
    logic [lcgsd_pkg::IDX_W-1:0]  r_rnd, n_rnd;
    logic [lcgsd_pkg::IDX_W-1:0]  r_x, n_x;
    logic [lcgsd_pkg::IDX_W-1:0]  r_ti, n_ti;
    logic [lcgsd_pkg::IDX_W-1:0]  r_slice_dest, n_slice_dest;

    logic [lcgsd_pkg::SEED_W-1:0]  w_seed_nx;
    logic [2*lcgsd_pkg::IDX_W-1:0] w_prod;
    logic                          w_we;
    logic [lcgsd_pkg::IDX_W-1:0]   w_waddr;
    logic [lcgsd_pkg::IDX_W-1:0]   w_wdata;
    logic [lcgsd_pkg::IDX_W-1:0]   w_raddr;
    logic [lcgsd_pkg::IDX_W-1:0]   w_rdata;
    logic                          w_done;

    assign w_seed_nx = lcgsd_pkg::SEED_W'(r_seed * lcgsd_pkg::LCG_MUL + lcgsd_pkg::LCG_INC);
    assign w_prod    = {{lcgsd_pkg::IDX_W{1'b0}}, r_rnd} * {{lcgsd_pkg::IDX_W{1'b0}}, r_i};

    always_comb begin
        n_state      = r_state;
        n_seed       = r_seed;
        n_fill_cnt   = r_fill_cnt;
        n_last       = r_last;
        n_i          = r_i;
        n_rnd        = r_rnd;
        n_x          = r_x;
        n_ti         = r_ti;
        n_slice_dest = r_slice_dest;
        w_we         = 1'b0;
        w_waddr      = r_i;
        w_wdata      = w_rdata;
        w_raddr      = r_i;
        w_done       = 1'b0;
        if (i_cmd.reseed) begin
            n_seed = i_cmd.seed;
        end
        unique case (r_state)
            lcgsd_pkg::P_IDLE: begin
                if (i_cmd.fill) begin
                    n_fill_cnt = '0;
                    n_last     = i_cmd.last_idx;
                    n_state    = lcgsd_pkg::P_FILL;
                end else if (i_cmd.slice) begin
                    n_i     = i_cmd.slice_idx;
                    n_state = lcgsd_pkg::P_LCG;
                end
            end
            lcgsd_pkg::P_FILL: begin
                w_we    = 1'b1;
                w_waddr = r_fill_cnt;
                w_wdata = r_fill_cnt;
                if (r_fill_cnt == r_last) begin
                    w_done  = 1'b1;
                    n_state = lcgsd_pkg::P_IDLE;
                end else begin
                    n_fill_cnt = r_fill_cnt + 1'b1;
                end
            end
            lcgsd_pkg::P_LCG: begin
                n_seed  = w_seed_nx;
                n_rnd   = {1'b0, w_seed_nx} + lcgsd_pkg::RND_OFS;
                n_state = lcgsd_pkg::P_MUL;
            end
            lcgsd_pkg::P_MUL: begin
                n_x     = w_prod[2*lcgsd_pkg::IDX_W-1:lcgsd_pkg::IDX_W];
                n_state = lcgsd_pkg::P_RDI;
            end
            lcgsd_pkg::P_RDI: begin
                w_raddr = r_i;
                n_state = lcgsd_pkg::P_RDX;
            end
            lcgsd_pkg::P_RDX: begin
                w_raddr = r_x;
                n_ti    = w_rdata;
                n_state = lcgsd_pkg::P_WRI;
            end
            lcgsd_pkg::P_WRI: begin
                // entry x moves to i and becomes the slice destination
                w_we         = 1'b1;
                w_waddr      = r_i;
                w_wdata      = w_rdata;
                n_slice_dest = w_rdata;
                n_state      = lcgsd_pkg::P_WRX;
            end
            lcgsd_pkg::P_WRX: begin
                w_we    = 1'b1;
                w_waddr = r_x;
                w_wdata = r_ti;
                w_done  = 1'b1;
                n_state = lcgsd_pkg::P_IDLE;
            end
            default: begin
                n_state = lcgsd_pkg::P_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lcgsd_pkg::P_IDLE;
            r_seed  <= '0;
        end else begin
            r_state <= n_state;
            r_seed  <= n_seed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill_cnt   <= n_fill_cnt;
        r_last       <= n_last;
        r_i          <= n_i;
        r_rnd        <= n_rnd;
        r_x          <= n_x;
        r_ti         <= n_ti;
        r_slice_dest <= n_slice_dest;
    end

    lcgsd_ram #(
        .WIDTH(lcgsd_pkg::IDX_W),
        .DEPTH(lcgsd_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign o_sts.done       = w_done;
    assign o_sts.slice_dest = r_slice_dest;

    `LCGSD_ASSERT_IMP(a_cmd_when_idle, i_cmd.fill || i_cmd.slice, r_state == lcgsd_pkg::P_IDLE)
    `LCGSD_ASSERT_IMP(a_cmd_exclusive, i_cmd.fill, !i_cmd.slice)
    `LCGSD_ASSERT_IMP(a_swap_in_range, r_state == lcgsd_pkg::P_RDI, r_x <= r_i)
    `LCGSD_ASSERT_NXT(a_done_to_idle, w_done, r_state == lcgsd_pkg::P_IDLE)

endmodule

// File: rtl/lcg_slice_shuffle_descrambler.sv
// top level: byte sequencer, chunk/slice counters and output register
// depends on lcgsd_pkg, lcgsd_perm and the assertion header
//
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_ready    | i_data_byte, i_first_of_image
//  out     | output    | o_out_valid / i_out_ready  | o_dest_offset, o_out_byte, o_last_of_image
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_image_size
//
// a byte inside a slice is accepted, then loaded into the output register
// the first byte of a slice also waits for generator step, multiply and table swap
// a chunk start adds a size search plus one table write per slice
// of the chunk, all through the single write port of the index table
// reset is synchronous; the table needs no clear since each chunk refills it
// a stalled output holds the sequencer until the output register frees up
`include "lcg_slice_shuffle_descrambler_assert.svh"

module lcg_slice_shuffle_descrambler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_of_image,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [25:0] o_dest_offset,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_image,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [26:0] i_cfg_image_size
);

    lcgsd_pkg::t_top_state r_state, n_state;

    logic [lcgsd_pkg::SIZE_W-1:0] r_image_size;
    logic [lcgsd_pkg::SIZE_W-1:0] r_remaining, n_remaining;
    logic [lcgsd_pkg::CNT_W-1:0]  r_chunk_slices, n_chunk_slices;
    logic [lcgsd_pkg::CNT_W-1:0]  r_slice_cnt, n_slice_cnt;
    logic [lcgsd_pkg::BIS_W-1:0]  r_bis, n_bis;
    logic [lcgsd_pkg::OFS_W-1:0]  r_chunk_base, n_chunk_base;
    logic                         r_sliced, n_sliced;
    logic                         r_out_valid, n_out_valid;
    logic [7:0]                   r_data, n_data;
    logic [lcgsd_pkg::OFS_W-1:0]  r_dest, n_dest;
    logic [7:0]                   r_obyte, n_obyte;
    logic                         r_last, n_last;

    lcgsd_pkg::t_perm_cmd w_cmd;
    lcgsd_pkg::t_perm_sts w_sts;

    logic                        w_rem_nz;
    logic                        w_can_load;
    logic [lcgsd_pkg::CNT_W-1:0] w_cnt_dec;
    logic [lcgsd_pkg::CNT_W-1:0] w_chunk_dec;

    assign w_rem_nz    = (r_remaining != '0);
    assign w_can_load  = !r_out_valid || i_out_ready;
    assign w_cnt_dec   = r_slice_cnt - 1'b1;
    assign w_chunk_dec = r_chunk_slices - 1'b1;

    always_comb begin
        n_state        = r_state;
        n_remaining    = r_remaining;
        n_chunk_slices = r_chunk_slices;
        n_slice_cnt    = r_slice_cnt;
        n_bis          = r_bis;
        n_chunk_base   = r_chunk_base;
        n_sliced       = r_sliced;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_data         = r_data;
        n_dest         = r_dest;
        n_obyte        = r_obyte;
        n_last         = r_last;
        w_cmd          = '0;
        unique case (r_state)
            lcgsd_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_data  = i_data_byte;
                    n_state = lcgsd_pkg::S_BYTE;
                    if (i_first_of_image) begin
                        n_remaining    = r_image_size;
                        n_chunk_slices = lcgsd_pkg::CNT_W'(lcgsd_pkg::MAX_CHUNK_SLICES);
                        n_slice_cnt    = '0;
                        n_bis          = '0;
                        n_chunk_base   = '0;
                        n_sliced       = 1'b0;
                        w_cmd.reseed   = 1'b1;
                        w_cmd.seed     = r_image_size[lcgsd_pkg::SEED_W-1:0];
                    end
                end
            end
            lcgsd_pkg::S_BYTE: begin
                if (w_rem_nz && r_slice_cnt == '0 && r_bis == '0 &&
                    r_remaining >= lcgsd_pkg::SIZE_W'(lcgsd_pkg::SLICE_BYTES)) begin
                    n_chunk_slices = lcgsd_pkg::CNT_W'(lcgsd_pkg::MAX_CHUNK_SLICES);
                    n_state        = lcgsd_pkg::S_SIZE;
                end else if (w_rem_nz && r_slice_cnt != '0 && r_bis == '0 && !r_sliced) begin
                    w_cmd.slice     = 1'b1;
                    w_cmd.slice_idx = w_cnt_dec[lcgsd_pkg::IDX_W-1:0];
                    n_state         = lcgsd_pkg::S_SLICE;
                end else if (w_can_load) begin
                    n_out_valid = 1'b1;
                    n_obyte     = r_data;
                    n_last      = (r_remaining == lcgsd_pkg::SIZE_W'(1));
                    n_state     = lcgsd_pkg::S_IDLE;
                    if (!w_rem_nz || r_slice_cnt == '0) begin
                        // past the end or tail shorter than a slice: in order
                        n_dest       = r_chunk_base;
                        n_chunk_base = r_chunk_base + 1'b1;
                    end else begin
                        n_dest = r_chunk_base +
                                 lcgsd_pkg::OFS_W'({w_sts.slice_dest, r_bis});
                        n_bis  = r_bis + 1'b1;
                        if (r_bis == lcgsd_pkg::BIS_W'(lcgsd_pkg::SLICE_BYTES - 1)) begin
                            n_sliced    = 1'b0;
                            n_slice_cnt = w_cnt_dec;
                            if (w_cnt_dec == '0) begin
                                n_chunk_base = r_chunk_base +
                                    lcgsd_pkg::OFS_W'({r_chunk_slices,
                                                       {lcgsd_pkg::BIS_W{1'b0}}});
                            end
                        end
                    end
                    if (w_rem_nz) begin
                        n_remaining = r_remaining - 1'b1;
                    end
                end
            end
            lcgsd_pkg::S_SIZE: begin
                // halve until the chunk fits in the bytes left
                if (r_chunk_slices > lcgsd_pkg::CNT_W'(1) &&
                    lcgsd_pkg::SIZE_W'({r_chunk_slices, {lcgsd_pkg::BIS_W{1'b0}}})
                        > r_remaining) begin
                    n_chunk_slices = r_chunk_slices >> 1;
                end else begin
                    n_slice_cnt    = r_chunk_slices;
                    w_cmd.fill     = 1'b1;
                    w_cmd.last_idx = w_chunk_dec[lcgsd_pkg::IDX_W-1:0];
                    n_state        = lcgsd_pkg::S_FILL;
                end
            end
            lcgsd_pkg::S_FILL: begin
                if (w_sts.done) begin
                    n_state = lcgsd_pkg::S_BYTE;
                end
            end
            lcgsd_pkg::S_SLICE: begin
                if (w_sts.done) begin
                    n_sliced = 1'b1;
                    n_state  = lcgsd_pkg::S_BYTE;
                end
            end
            default: begin
                n_state = lcgsd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= lcgsd_pkg::S_IDLE;
            r_image_size   <= '0;
            r_remaining    <= '0;
            r_chunk_slices <= lcgsd_pkg::CNT_W'(lcgsd_pkg::MAX_CHUNK_SLICES);
            r_slice_cnt    <= '0;
            r_bis          <= '0;
            r_chunk_base   <= '0;
            r_sliced       <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_remaining    <= n_remaining;
            r_chunk_slices <= n_chunk_slices;
            r_slice_cnt    <= n_slice_cnt;
            r_bis          <= n_bis;
            r_chunk_base   <= n_chunk_base;
            r_sliced       <= n_sliced;
            r_out_valid    <= n_out_valid;
            if (i_cfg_valid) begin
                r_image_size <= i_cfg_image_size;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_dest  <= n_dest;
        r_obyte <= n_obyte;
        r_last  <= n_last;
    end

    lcgsd_perm u_perm (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (w_cmd),
        .o_sts  (w_sts)
    );

    assign o_in_ready      = (r_state == lcgsd_pkg::S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_dest_offset   = r_dest;
    assign o_out_byte      = r_obyte;
    assign o_last_of_image = r_last;
    assign o_cfg_ready     = 1'b1;

    `LCGSD_ASSERT_IMP(a_bis_needs_slice, r_bis != '0, r_slice_cnt != '0 && r_sliced)
    `LCGSD_ASSERT_IMP(a_slice_wait_count, r_state == lcgsd_pkg::S_SLICE, r_slice_cnt != '0)
    `LCGSD_ASSERT_IMP(a_no_done_when_idle, r_state == lcgsd_pkg::S_IDLE, !w_sts.done)
    `LCGSD_ASSERT_NXT(a_accept_goes_busy, i_in_valid && o_in_ready, !o_in_ready)

endmodule
